// ===== hdl/htlp_pkg.sv =====
`default_nettype none

package htlp_pkg;

	// Table geometry. Home slot is value mod SLOTS; SLOTS is kept a power of two
	// so the mod is a mask.
	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int VAL_W  = 31;
	localparam int QDEPTH = 2;

	typedef logic [SLOT_W-1:0] sidx_t;

	// Request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	// Result status codes
	localparam logic [2:0] STAT_INSERTED = 3'd0;
	localparam logic [2:0] STAT_FULL     = 3'd1;
	localparam logic [2:0] STAT_FOUND    = 3'd2;
	localparam logic [2:0] STAT_MISSING  = 3'd3;
	localparam logic [2:0] STAT_DELETED  = 3'd4;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_SEARCH,
		OP_DELETE,
		OP_NONE
	} op_t;

	// Classified request as it sits in the queue between front and back
	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] value;
		sidx_t            home;
	} job_t;

	typedef enum logic {
		BK_IDLE,
		BK_PROBE
	} bk_state_t;

	// Low four bits of a slot index, zero extended for small tables
	function automatic logic [3:0] slot_field(input sidx_t idx);
		logic [7:0] w;
		w = 8'(idx);
		return w[3:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/hash_table_linear_probe_unit.sv =====
// Flow: an accepted request waits in the front queue, is popped by the back
//   when idle and probed one table slot per cycle until a hit, an unused
//   request code or a full scan; the result is then registered. The back takes
//   one request at a time while the front queue accepts requests until full.
// Reset: arst_n async low; table empties at once (valid bits cleared),
//   queue and output register flushed. No clearing pass.
`default_nettype none

module hash_table_linear_probe_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire htlp_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output htlp_pkg::rsp_t      rsp
);
	import htlp_pkg::*;

	// Front to back: classified request (op, value, home slot)
	logic job_valid;
	logic job_pop;
	job_t job;

	// Front: takes requests, decodes the request code, computes the home slot
	// and parks the result in a small queue so a long probe does not block
	// the input channel.
	htlp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job)
	);

	// Back: owns the table. Walks slots from home upward with wrap, one per
	// cycle, stops on the first empty slot (insert), first valid match (search/
	// delete), the home slot (unused code) or after all SLOTS slots. Result lands
	// in an output register; the engine holds while that register is still occupied.
	htlp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== hdl/htlp_front.sv =====
`default_nettype none

module htlp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire htlp_pkg::req_t req,
	output logic                job_valid,
	input  wire logic           job_pop,
	output htlp_pkg::job_t      job
);
	import htlp_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	job_t              fifo_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	job_t              new_job;
	logic              push;
	logic              pop;

	// classify and compute home slot
	always_comb begin
		new_job.value = req.value;
		new_job.home  = SLOT_W'(req.value % SLOTS);
		case (req.req_type)
			REQ_INSERT: new_job.op = OP_INSERT;
			REQ_SEARCH: new_job.op = OP_SEARCH;
			REQ_DELETE: new_job.op = OP_DELETE;
			default:    new_job.op = OP_NONE;
		endcase
	end

	assign req_ready = (count_q != CNT_W'(QDEPTH));
	assign push      = req_valid && req_ready;
	assign job_valid = (count_q != '0);
	assign pop       = job_pop && job_valid;
	assign job       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/htlp_back.sv =====
`default_nettype none

module htlp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	output logic                job_pop,
	input  wire htlp_pkg::job_t job,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output htlp_pkg::rsp_t      rsp
);
	import htlp_pkg::*;

	logic [VAL_W-1:0] slot_value [SLOTS];
	logic [SLOTS-1:0] slot_valid_q;

	bk_state_t        state_q, state_d;
	op_t              op_q;
	logic [VAL_W-1:0] value_q;
	sidx_t            idx_q;
	sidx_t            cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic cur_valid;
	logic hit;
	logic last;
	logic out_free;
	logic finish;
	logic load_job;
	logic advance;
	rsp_t result;

	assign cur_valid = slot_valid_q[idx_q];
	assign last      = (cnt_q == SLOT_W'(SLOTS - 1));
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		case (op_q)
			OP_INSERT: hit = !cur_valid;
			OP_SEARCH,
			OP_DELETE: hit = cur_valid && (slot_value[idx_q] == value_q);
			default:   hit = 1'b1;
		endcase

		result.slot = hit ? slot_field(idx_q) : 4'd0;
		case (op_q)
			OP_INSERT: result.status = hit ? STAT_INSERTED : STAT_FULL;
			OP_SEARCH: result.status = hit ? STAT_FOUND : STAT_MISSING;
			OP_DELETE: result.status = hit ? STAT_DELETED : STAT_MISSING;
			default: begin
				result.status = STAT_MISSING;
				result.slot   = 4'd0;
			end
		endcase
	end

	// sequencer: pop a job, walk the probe sequence, retire into the output reg
	always_comb begin
		state_d  = state_q;
		load_job = 1'b0;
		advance  = 1'b0;
		finish   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					load_job = 1'b1;
					state_d  = BK_PROBE;
				end
			end
			BK_PROBE: begin
				if (hit || last) begin
					if (out_free) begin
						finish  = 1'b1;
						state_d = BK_IDLE;
					end
				end else begin
					advance = 1'b1;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign job_pop   = load_job;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (load_job) begin
			op_q    <= job.op;
			value_q <= job.value;
			idx_q   <= job.home;
			cnt_q   <= '0;
		end else if (advance) begin
			idx_q <= (idx_q == SLOT_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (finish) begin
			rsp_q <= result;
		end
		if (finish && hit && (op_q == OP_INSERT)) begin
			slot_value[idx_q] <= value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			rsp_valid_q  <= 1'b0;
			slot_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (finish && hit && (op_q == OP_INSERT)) begin
				slot_valid_q[idx_q] <= 1'b1;
			end
			if (finish && hit && (op_q == OP_DELETE)) begin
				slot_valid_q[idx_q] <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
